@@ rtl/weighted_note_sampler_core_macros.svh @@
// Assertion macros for the weighted note sampler checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef WEIGHTED_NOTE_SAMPLER_CORE_MACROS_SVH
`define WEIGHTED_NOTE_SAMPLER_CORE_MACROS_SVH

// Clocked assertion with a fixed failure message.
`define WNS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("weighted note sampler check failed");

// Clocked assertion with a caller-supplied failure message.
`define WNS_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

@@ rtl/wns_pkg.sv @@
// Shared constants and types for the weighted note sampler.
// No dependencies; imported by the core and the checker.
`default_nettype none

package wns_pkg;

  localparam int NOTE_COUNT    = 36;
  localparam int MAX_POSITIONS = 128;

  localparam int NOTE_W   = $clog2(NOTE_COUNT);
  localparam int IDX_W    = NOTE_W + 1;
  localparam int POS_W    = $clog2(MAX_POSITIONS);
  localparam int WEIGHT_W = 16;
  localparam int RND_W    = 32;
  localparam int BIT_W    = $clog2(RND_W);
  localparam int LEN_W    = 8;
  localparam int OUT_NOTE_W = 6;

  // Sum of all weights at one position never exceeds NOTE_COUNT * 65535.
  localparam int SUM_W    = $clog2(NOTE_COUNT * 65535 + 1);

  localparam int WT_DEPTH = NOTE_COUNT * MAX_POSITIONS;
  localparam int WT_AW    = NOTE_W + POS_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_INIT = 16'd1000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN  = 16'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = 16'd65535;
  localparam logic [LEN_W-1:0]    SONG_LENGTH_RESET = 8'd100;

  localparam logic MODE_GENERATE = 1'b0;
  localparam logic MODE_FEEDBACK = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_MOD,
    ST_SCAN,
    ST_FB_LS,
    ST_FB_W,
    ST_FB_WR
  } state_t;

endpackage

`default_nettype wire

@@ rtl/wns_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies; used for the weight table and the last-song store.
`default_nettype none

module wns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ rtl/weighted_note_sampler_core.sv @@
// Roulette-wheel note sampler with a learned weight table and feedback walk.
// Depends on wns_pkg and wns_ram.
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+-----------------------
//  command  | in_mode in_position in_random_value in_good    | start & !busy
//  result   | out_note out_update_done                       | out_valid, one cycle
//  config   | cfg_data (song_length)                         | cfg_valid & cfg_ready
//
// After reset the block sweeps the weight table, one entry a cycle, while busy is high;
// config words are taken during the sweep as at any time.
// A generate word sums the weights, forms the bit-serial remainder, then scans spans,
// all through one shared adder and one RAM port.
// A feedback word walks min(song_length, 128) positions, updating one weight at each;
// a song length of zero reports done on the next cycle.
// The result strobe cannot be stalled; busy falls as it rises.
`default_nettype none

module weighted_note_sampler_core
  import wns_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic                  in_mode,
  input  wire logic [6:0]            in_position,
  input  wire logic [31:0]           in_random_value,
  input  wire logic                  in_good,
  output      logic                  out_valid,
  output      logic [OUT_NOTE_W-1:0] out_note,
  output      logic                  out_update_done,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [LEN_W-1:0]      cfg_data
);

  state_t state_r, state_nxt;

  logic [WT_AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [LEN_W-1:0]    song_length_r;
  logic                out_valid_r, out_valid_nxt;
  logic [NOTE_W-1:0]   out_note_r, out_note_nxt;
  logic                out_done_r, out_done_nxt;

  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [RND_W-1:0]    rnd_r, rnd_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [SUM_W-1:0]    rem_r, rem_nxt;
  logic [SUM_W-1:0]    start_r, start_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic                good_r, good_nxt;
  logic [NOTE_W-1:0]   note_r, note_nxt;

  // Weight table and last-song store
  logic                wt_we;
  logic [WT_AW-1:0]    wt_addr;
  logic [WEIGHT_W-1:0] wt_wdata, wt_rdata;
  logic                ls_we;
  logic [POS_W-1:0]    ls_addr;
  logic [NOTE_W-1:0]   ls_wdata, ls_rdata;

  // Shared adder / subtractor
  logic [SUM_W:0]      alu_a, alu_b;
  logic                alu_sub;
  logic [SUM_W+1:0]    alu_sum;

  logic [LEN_W-1:0]    fb_len;
  logic                fb_last;
  logic                accept;
  logic                scan_hit;
  logic                clr_last;
  logic [SUM_W:0]      div_trial;
  logic [NOTE_W-1:0]   ls_note;
  logic [NOTE_W-1:0]   scan_note;
  logic [WEIGHT_W-1:0] fb_weight;

  wns_ram #(.WIDTH(WEIGHT_W), .DEPTH(WT_DEPTH)) u_wt_ram (
    .clk   (clk),
    .we    (wt_we),
    .addr  (wt_addr),
    .wdata (wt_wdata),
    .rdata (wt_rdata)
  );

  wns_ram #(.WIDTH(NOTE_W), .DEPTH(MAX_POSITIONS)) u_ls_ram (
    .clk   (clk),
    .we    (ls_we),
    .addr  (ls_addr),
    .wdata (ls_wdata),
    .rdata (ls_rdata)
  );

  assign busy            = (state_r != ST_IDLE);
  assign accept          = start && !busy;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_note        = OUT_NOTE_W'(out_note_r);
  assign out_update_done = out_done_r;

  assign fb_len   = (song_length_r > LEN_W'(MAX_POSITIONS)) ? LEN_W'(MAX_POSITIONS)
                                                            : song_length_r;
  assign fb_last  = (LEN_W'(pos_r) + LEN_W'(1)) == fb_len;
  assign clr_last = (clr_addr_r == WT_AW'(WT_DEPTH - 1));

  assign alu_sum = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
                 + (SUM_W+2)'(alu_sub);

  assign div_trial = {rem_r, rnd_r[RND_W-1]};
  // A recorded note out of range stands for note 0
  assign ls_note   = (ls_rdata >= NOTE_W'(NOTE_COUNT)) ? '0 : ls_rdata;
  assign scan_note = NOTE_W'(idx_r - IDX_W'(1));
  // Last note always wins: the remainder is below the sum
  assign scan_hit  = (idx_r != '0) &&
                     (({1'b0, rem_r} < alu_sum[SUM_W:0]) || (idx_r == IDX_W'(NOTE_COUNT)));
  assign fb_weight = good_r ? ((wt_rdata != WEIGHT_MAX) ? wt_rdata + WEIGHT_W'(1) : wt_rdata)
                            : ((wt_rdata >  WEIGHT_MIN) ? wt_rdata - WEIGHT_W'(1) : wt_rdata);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_GENERATE) begin
            state_nxt = ST_SUM;
          end else if (fb_len != '0) begin
            state_nxt = ST_FB_LS;
          end
        end
      end
      ST_SUM: begin
        if (idx_r == IDX_W'(NOTE_COUNT)) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (bit_r == BIT_W'(RND_W - 1)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_hit) state_nxt = ST_IDLE;
      end
      ST_FB_LS: state_nxt = ST_FB_W;
      ST_FB_W:  state_nxt = ST_FB_WR;
      ST_FB_WR: begin
        state_nxt = fb_last ? ST_IDLE : ST_FB_LS;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Memory controls and result strobe
  always_comb begin
    wt_we         = 1'b0;
    wt_addr       = '0;
    wt_wdata      = WEIGHT_INIT;
    ls_we         = 1'b0;
    ls_addr       = pos_r;
    ls_wdata      = '0;
    out_valid_nxt = 1'b0;
    out_note_nxt  = out_note_r;
    out_done_nxt  = out_done_r;
    unique case (state_r)
      ST_CLEAR: begin
        wt_we    = 1'b1;
        wt_addr  = clr_addr_r;
        ls_we    = (clr_addr_r < WT_AW'(MAX_POSITIONS));
        ls_addr  = clr_addr_r[POS_W-1:0];
      end
      ST_IDLE: begin
        // Empty walk: report done at once
        if (accept && in_mode == MODE_FEEDBACK && fb_len == '0) begin
          out_valid_nxt = 1'b1;
          out_note_nxt  = '0;
          out_done_nxt  = 1'b1;
        end
      end
      ST_SUM, ST_SCAN: begin
        if (idx_r < IDX_W'(NOTE_COUNT)) begin
          wt_addr = {idx_r[NOTE_W-1:0], pos_r};
        end
        if (state_r == ST_SCAN && scan_hit) begin
          ls_we         = 1'b1;
          ls_wdata      = scan_note;
          out_valid_nxt = 1'b1;
          out_note_nxt  = scan_note;
          out_done_nxt  = 1'b0;
        end
      end
      ST_MOD: begin
      end
      ST_FB_LS: begin
        ls_addr = pos_r;
      end
      ST_FB_W: begin
        wt_addr = {ls_note, pos_r};
      end
      ST_FB_WR: begin
        wt_we    = 1'b1;
        wt_addr  = {note_r, pos_r};
        wt_wdata = fb_weight;
        if (fb_last) begin
          out_valid_nxt = 1'b1;
          out_note_nxt  = '0;
          out_done_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Datapath
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    rnd_nxt      = rnd_r;
    acc_nxt      = acc_r;
    rem_nxt      = rem_r;
    start_nxt    = start_r;
    bit_nxt      = bit_r;
    good_nxt     = good_r;
    note_nxt     = note_r;
    alu_a        = {1'b0, acc_r};
    alu_b        = {{(SUM_W+1-WEIGHT_W){1'b0}}, wt_rdata};
    alu_sub      = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + WT_AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          idx_nxt  = '0;
          acc_nxt  = '0;
          pos_nxt  = POS_W'(in_position);
          rnd_nxt  = in_random_value;
          good_nxt = in_good;
          if (in_mode == MODE_FEEDBACK) pos_nxt = '0;
        end
      end
      ST_SUM: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r != '0) acc_nxt = alu_sum[SUM_W-1:0];
        rem_nxt = '0;
        bit_nxt = '0;
      end
      ST_MOD: begin
        // Restoring remainder, one dividend bit a cycle
        alu_a   = div_trial;
        alu_b   = {1'b0, acc_r};
        alu_sub = 1'b1;
        rem_nxt = alu_sum[SUM_W+1] ? div_trial[SUM_W-1:0] : alu_sum[SUM_W-1:0];
        rnd_nxt = {rnd_r[RND_W-2:0], 1'b0};
        bit_nxt = bit_r + BIT_W'(1);
        idx_nxt   = '0;
        start_nxt = '0;
      end
      ST_SCAN: begin
        alu_a   = {1'b0, start_r};
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r != '0) start_nxt = alu_sum[SUM_W-1:0];
      end
      ST_FB_LS: begin
      end
      ST_FB_W: begin
        note_nxt = ls_note;
      end
      ST_FB_WR: begin
        pos_nxt = pos_r + POS_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      song_length_r <= SONG_LENGTH_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        song_length_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_note_r <= out_note_nxt;
    out_done_r <= out_done_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    rnd_r      <= rnd_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    start_r    <= start_nxt;
    bit_r      <= bit_nxt;
    good_r     <= good_nxt;
    note_r     <= note_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/wns_checker.sv @@
// Port-level checker for the weighted note sampler, bound to the top level.
// Depends on wns_pkg and weighted_note_sampler_core_macros.svh.
`default_nettype none
`include "weighted_note_sampler_core_macros.svh"

module wns_checker
  import wns_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  in_mode,
  input wire logic                  out_valid,
  input wire logic [OUT_NOTE_W-1:0] out_note,
  input wire logic                  out_update_done
);

  // A generated note lies within the note range
  `WNS_ASSERT_MSG(a_note_range, clk, rst_n, out_valid && !out_update_done |-> out_note < NOTE_COUNT, "note out of range")

  // A feedback result always reports note zero
  `WNS_ASSERT(a_fb_note_zero, clk, rst_n, out_valid && out_update_done |-> out_note == '0)

  // A generate word keeps the block busy on the next cycle
  `WNS_ASSERT(a_gen_busy, clk, rst_n, start && !busy && in_mode == MODE_GENERATE |=> busy)

  // A note result closes a busy period
  `WNS_ASSERT_MSG(a_note_after_busy, clk, rst_n, out_valid && !out_update_done |-> $past(busy), "note without work")

  // No word accepted while idle: no result follows
  `WNS_ASSERT(a_no_spurious, clk, rst_n, !busy && !start |=> !out_valid)

endmodule

bind weighted_note_sampler_core wns_checker u_wns_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_mode         (in_mode),
  .out_valid       (out_valid),
  .out_note        (out_note),
  .out_update_done (out_update_done)
);

`default_nettype wire
